// ===== rtl/core/bpe_pkg.sv =====
// Shared types and constants for the binomial prime exponent engine.
// Used by the top level and bpe_ctrl under rtl/core; depends on nothing else.
package bpe_pkg;

    // Fixed port widths of the payload and the configuration bus.
    localparam int FIELD_W      = 32;
    localparam int EXP_W        = 6;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;

    // Default width of the internal arithmetic.
    localparam int VALUE_BITS_DEF = 32;

    // Register indexes, taken from paddr bit 2.
    localparam logic REG_N_TOTAL  = 1'b0;
    localparam logic REG_K_CHOSEN = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_N_DIV,
        ST_K_DIV
    } t_state;

endpackage

// ===== rtl/core/binomial_prime_exponent_engine.sv =====
// Top level of the binomial prime exponent engine: APB registers and wiring.
// Depends on bpe_pkg, bpe_div and bpe_ctrl.
//
// For each prime accepted on start (when busy is low) the engine reports the
// exponent of that prime in C(n,k), with n and k taken from the n_total and
// k_chosen registers. The exponent is counted as the number of borrows when k
// is subtracted from n in base p. Each base-p digit of n needs two divisions
// on the single shared bit-serial divider, so an item holds busy through
// 2 * D divisions in turn, D being the number of base-p digits of n (two for
// a prime above the square root of n, the fewest an item that is not dropped
// can have). An item with k above n, a prime above n or a prime below two is
// dropped in its accept cycle and gives no result.
// A result appears with o_valid for exactly one cycle only when the exponent
// is nonzero; the receiver cannot stall it, so it must take every transfer.
module binomial_prime_exponent_engine #(
    parameter int VALUE_BITS = bpe_pkg::VALUE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bpe_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bpe_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bpe_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           start,
    output logic                           busy,
    input  logic [bpe_pkg::FIELD_W-1:0]    i_prime,
    output logic                           o_valid,
    output logic [bpe_pkg::FIELD_W-1:0]    o_prime_out,
    output logic [bpe_pkg::EXP_W-1:0]      o_exponent
);

    logic [VALUE_BITS-1:0] r_n_total;
    logic [VALUE_BITS-1:0] r_k_chosen;

    logic                  cfg_write;
    logic                  div_go;
    logic [VALUE_BITS-1:0] div_dividend;
    logic [VALUE_BITS-1:0] div_divisor;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quotient;
    logic [VALUE_BITS-1:0] div_remainder;
    logic [VALUE_BITS-1:0] prime_out;

    // Configuration registers, written in the APB access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_total  <= '0;
            r_k_chosen <= '0;
        end else if (cfg_write) begin
            if (paddr[2] == bpe_pkg::REG_N_TOTAL) begin
                r_n_total <= VALUE_BITS'(pwdata);
            end
            if (paddr[2] == bpe_pkg::REG_K_CHOSEN) begin
                r_k_chosen <= VALUE_BITS'(pwdata);
            end
        end
    end

    // Register read back.
    always_comb begin
        unique case (paddr[2])
            bpe_pkg::REG_N_TOTAL:  prdata = bpe_pkg::APB_DATA_W'(r_n_total);
            bpe_pkg::REG_K_CHOSEN: prdata = bpe_pkg::APB_DATA_W'(r_k_chosen);
            default:               prdata = '0;
        endcase
    end

    // Sequencer.
    bpe_ctrl #(
        .W (VALUE_BITS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_n             (r_n_total),
        .i_k             (r_k_chosen),
        .i_prime         (VALUE_BITS'(i_prime)),
        .o_div_go        (div_go),
        .o_div_dividend  (div_dividend),
        .o_div_divisor   (div_divisor),
        .i_div_done      (div_done),
        .i_div_quotient  (div_quotient),
        .i_div_remainder (div_remainder),
        .o_busy          (busy),
        .o_valid         (o_valid),
        .o_prime         (prime_out),
        .o_exponent      (o_exponent)
    );

    // Shared divider.
    bpe_div #(
        .W (VALUE_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (div_go),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quotient),
        .o_remainder (div_remainder)
    );

    assign o_prime_out = bpe_pkg::FIELD_W'(prime_out);

endmodule

// ===== rtl/core/bpe_div.sv =====
// Bit-serial restoring divider shared by all digit extractions.
// Depends on nothing but its parameter; one quotient bit per cycle.
module bpe_div #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_go,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient,
    output logic [W-1:0] o_remainder
);

    localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_dvs;
    logic [W:0]       trial;

    // Trial subtraction of the divisor from the shifted partial remainder.
    assign trial = {r_rem, r_quo[W-1]} - {1'b0, r_dvs};

    // Control: count W steps after a go, then pulse done for one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Datapath: the dividend shifts out of r_quo as quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!trial[W]) begin
                r_rem <= trial[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[W-2:0], r_quo[W-1]};
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== rtl/core/bpe_ctrl.sv =====
// Sequencer that walks the base-p digits of n and k and counts borrows.
// Depends on bpe_pkg; drives the shared divider bpe_div.
module bpe_ctrl #(
    parameter int W = bpe_pkg::VALUE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [W-1:0]              i_n,
    input  logic [W-1:0]              i_k,
    input  logic [W-1:0]              i_prime,
    output logic                      o_div_go,
    output logic [W-1:0]              o_div_dividend,
    output logic [W-1:0]              o_div_divisor,
    input  logic                      i_div_done,
    input  logic [W-1:0]              i_div_quotient,
    input  logic [W-1:0]              i_div_remainder,
    output logic                      o_busy,
    output logic                      o_valid,
    output logic [W-1:0]              o_prime,
    output logic [bpe_pkg::EXP_W-1:0] o_exponent
);

    bpe_pkg::t_state r_state;
    bpe_pkg::t_state n_state;

    logic [W-1:0]              r_p;
    logic [W-1:0]              r_nq;
    logic [W-1:0]              r_nd;
    logic [W-1:0]              r_k;
    logic                      r_borrow;
    logic [bpe_pkg::EXP_W-1:0] r_exp;
    logic                      r_valid;

    logic                      accept;
    logic                      skip;
    logic                      borrow_new;
    logic [bpe_pkg::EXP_W-1:0] exp_next;
    logic                      last_digit;

    // An item with k above n, p below two or p above n gives no result.
    assign accept = i_start && (r_state == bpe_pkg::ST_IDLE);
    assign skip   = (i_k > i_n) || (i_prime[W-1:1] == '0) || (i_prime > i_n);

    // Borrow out of the current digit of n minus k (Kummer's theorem).
    assign borrow_new = {1'b0, r_nd} < ({1'b0, i_div_remainder} + (W+1)'(r_borrow));
    assign exp_next   = r_exp + bpe_pkg::EXP_W'(borrow_new);
    assign last_digit = (r_nq == '0);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bpe_pkg::ST_IDLE: begin
                if (accept && !skip) n_state = bpe_pkg::ST_N_DIV;
            end
            bpe_pkg::ST_N_DIV: begin
                if (i_div_done) n_state = bpe_pkg::ST_K_DIV;
            end
            bpe_pkg::ST_K_DIV: begin
                if (i_div_done) begin
                    n_state = last_digit ? bpe_pkg::ST_IDLE : bpe_pkg::ST_N_DIV;
                end
            end
            default: n_state = bpe_pkg::ST_IDLE;
        endcase
    end

    // Divider requests: n's digit first, then k's, per level.
    always_comb begin
        o_div_go       = 1'b0;
        o_div_dividend = r_nq;
        o_div_divisor  = r_p;
        unique case (r_state)
            bpe_pkg::ST_IDLE: begin
                o_div_go       = accept && !skip;
                o_div_dividend = i_n;
                o_div_divisor  = i_prime;
            end
            bpe_pkg::ST_N_DIV: begin
                o_div_go       = i_div_done;
                o_div_dividend = r_k;
            end
            bpe_pkg::ST_K_DIV: begin
                o_div_go       = i_div_done && !last_digit;
                o_div_dividend = r_nq;
            end
            default: o_div_go = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpe_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == bpe_pkg::ST_K_DIV) && i_div_done && last_digit
                       && (exp_next != '0);
        end
    end

    // Digit and exponent bookkeeping.
    always_ff @(posedge i_clk) begin
        if (accept && !skip) begin
            r_p      <= i_prime;
            r_nq     <= i_n;
            r_k      <= i_k;
            r_borrow <= 1'b0;
            r_exp    <= '0;
        end else if (i_div_done && (r_state == bpe_pkg::ST_N_DIV)) begin
            r_nq <= i_div_quotient;
            r_nd <= i_div_remainder;
        end else if (i_div_done && (r_state == bpe_pkg::ST_K_DIV)) begin
            r_k      <= i_div_quotient;
            r_borrow <= borrow_new;
            r_exp    <= exp_next;
        end
    end

    assign o_busy     = (r_state != bpe_pkg::ST_IDLE);
    assign o_valid    = r_valid;
    assign o_prime    = r_p;
    assign o_exponent = r_exp;

endmodule

// ===== tb/tb_binomial_prime_exponent_engine.sv =====
// Self-checking testbench for binomial_prime_exponent_engine: directed table, then random primes.
// Needs only bpe_pkg and the engine RTL; a Legendre-sum calculator predicts untyped exponents.
`timescale 1ns / 100ps

module tb_binomial_prime_exponent_engine;

    localparam int DRAIN_CYCLES = 2 * 32 * 33 + 32;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RAND_CONFIGS = 4;
    localparam int ITEMS_PER_CONFIG = 40;

    // One reported factor of C(n,k).
    typedef struct packed {
        logic [bpe_pkg::FIELD_W-1:0] prime;
        logic [bpe_pkg::EXP_W-1:0]   exponent;
    } t_factor;

    // One row of the directed table: a register write or a prime with an optional typed answer.
    typedef struct packed {
        logic                        is_cfg;
        logic                        reg_idx;
        logic [bpe_pkg::FIELD_W-1:0] value;
        logic                        typed;
        logic                        typed_hit;
        logic [bpe_pkg::EXP_W-1:0]   typed_exp;
    } t_row;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [bpe_pkg::APB_ADDR_W-1:0]   paddr;
    logic [bpe_pkg::APB_DATA_W-1:0]   pwdata;
    logic [bpe_pkg::APB_DATA_W-1:0]   prdata;
    logic                             pready;
    logic                             start;
    logic                             busy;
    logic [bpe_pkg::FIELD_W-1:0]      i_prime;
    logic                             o_valid;
    logic [bpe_pkg::FIELD_W-1:0]      o_prime_out;
    logic [bpe_pkg::EXP_W-1:0]        o_exponent;

    // Local copy of the configuration and the queue of factors still to come.
    logic [31:0] n_cfg;
    logic [31:0] k_cfg;
    t_factor     pending_factors[$];
    t_row        dir_rows[$];
    int          small_primes[$];

    // Typed answer that travels with the prime currently offered.
    logic                      cur_typed;
    logic                      cur_hit;
    logic [bpe_pkg::EXP_W-1:0] cur_exp;

    int errors;
    int primes_taken;
    int factors_checked;
    int cfg_writes;
    int idle_pct;
    int idle_cycles;

    binomial_prime_exponent_engine u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .start       (start),
        .busy        (busy),
        .i_prime     (i_prime),
        .o_valid     (o_valid),
        .o_prime_out (o_prime_out),
        .o_exponent  (o_exponent)
    );

    // Clock generation.
    always #2 i_clk = ~i_clk;

    // Legendre sum of m for base p, p at least two.
    function automatic longint unsigned legendre_total(input longint unsigned m,
                                                       input longint unsigned p);
        longint unsigned sum;
        longint unsigned q;
        bit done;
        sum = 0;
        q = p;
        done = 1'b0;
        while (!done && q <= m) begin
            sum += m / q;
            if (q > m / p) begin
                done = 1'b1;
            end else begin
                q *= p;
            end
        end
        return sum;
    endfunction

    // Exponent of p in C(n,k) under the current registers; returns 1 when a factor is reported.
    function automatic bit factor_exponent(input logic [31:0] p,
                                           output logic [bpe_pkg::EXP_W-1:0] e);
        longint unsigned n;
        longint unsigned k;
        longint unsigned s;
        n = n_cfg;
        k = k_cfg;
        e = '0;
        if (k > n || p < 2 || p > n) return 1'b0;
        s = legendre_total(n, p) - legendre_total(k, p) - legendre_total(n - k, p);
        if (s == 0) return 1'b0;
        if (s > 63) s = 63;
        e = s[bpe_pkg::EXP_W-1:0];
        return 1'b1;
    endfunction

    function automatic void add_cfg(input logic reg_idx, input logic [31:0] value);
        dir_rows.push_back({1'b1, reg_idx, value, 1'b0, 1'b0, 6'd0});
    endfunction

    function automatic void add_prime(input logic [31:0] p, input logic typed,
                                      input logic hit, input logic [bpe_pkg::EXP_W-1:0] e);
        dir_rows.push_back({1'b0, 1'b0, p, typed, hit, e});
    endfunction

    // Offer one prime after a gap and hold it until the engine takes it.
    task automatic send_prime(input logic [31:0] p, input logic typed, input logic hit,
                              input logic [bpe_pkg::EXP_W-1:0] e, input int gap);
        repeat (gap) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start = 1'b1;
        i_prime = p;
        cur_typed = typed;
        cur_hit = hit;
        cur_exp = e;
        do @(posedge i_clk); while (busy);
    endtask

    // Stop offering primes, wait for every expected factor, then optionally let the engine drain.
    task automatic settle(input bit drain);
        @(negedge i_clk);
        start = 1'b0;
        while (pending_factors.size() != 0) @(posedge i_clk);
        if (drain) repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write followed by a read-back check of the same register.
    task automatic write_reg(input logic reg_idx, input logic [31:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {reg_idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_idx == bpe_pkg::REG_N_TOTAL) begin
            n_cfg = value;
        end else begin
            k_cfg = value;
        end
        cfg_writes++;
        @(negedge i_clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== value) begin
            errors++;
            $display("%0t: register %0d read back expected %h actual %h",
                     $time, reg_idx, value, prdata);
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // Pick the next prime: mostly an ascending stream of small primes, the rest noise.
    function automatic logic [31:0] next_prime(inout int idx);
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) begin
            idx = (idx + 1) % small_primes.size();
            return small_primes[idx];
        end else if (roll < 85 && n_cfg >= 2) begin
            return $urandom_range(n_cfg, 2);
        end else if (roll < 95) begin
            return $urandom;
        end
        case ($urandom_range(3))
            0: return 32'd0;
            1: return 32'd1;
            2: return n_cfg;
            default: return n_cfg + 32'd1;
        endcase
    endfunction

    // Random setting of n and k covering small, medium, full-range and extreme values.
    task automatic random_config();
        logic [31:0] n;
        logic [31:0] k;
        case ($urandom_range(3))
            0: n = $urandom_range(300, 2);
            1: n = $urandom_range(200000, 300);
            2: n = $urandom;
            default: n = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
        endcase
        if ($urandom_range(7) == 0 && n < 32'hFFFF_FF00) begin
            k = n + $urandom_range(50, 1);
        end else begin
            k = $urandom_range(n, 0);
        end
        write_reg(bpe_pkg::REG_N_TOTAL, n);
        write_reg(bpe_pkg::REG_K_CHOSEN, k);
    endtask

    // Take accepted primes into the prediction queue and check every strobed result.
    always @(posedge i_clk) begin : scoreboard
        logic [bpe_pkg::EXP_W-1:0] e;
        bit hit;
        t_factor got;
        t_factor want;
        if (i_rst_n) begin
            if (start && !busy) begin
                if (cur_typed) begin
                    hit = cur_hit;
                    e = cur_exp;
                end else begin
                    hit = factor_exponent(i_prime, e);
                end
                if (hit) pending_factors.push_back({i_prime, e});
                primes_taken++;
            end
            if (o_valid) begin
                got = {o_prime_out, o_exponent};
                if (pending_factors.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %0d ^ %0d",
                             $time, o_prime_out, o_exponent);
                end else begin
                    want = pending_factors.pop_front();
                    factors_checked++;
                    if (got.prime !== want.prime) begin
                        errors++;
                        $display("%0t: prime_out expected %0d actual %0d",
                                 $time, want.prime, got.prime);
                    end
                    if (got.exponent !== want.exponent) begin
                        errors++;
                        $display("%0t: exponent of %0d expected %0d actual %0d",
                                 $time, want.prime, want.exponent, got.exponent);
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles in which no transfer of any kind happens.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (psel && penable && pready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired at %0t", $time);
            $display("tb: failure");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random phases, final drain and verdict.
    initial begin : stimulus
        int idx;
        int gap;
        t_row row;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        i_prime = '0;
        cur_typed = 1'b0;
        cur_hit = 1'b0;
        cur_exp = '0;
        n_cfg = '0;
        k_cfg = '0;
        errors = 0;
        primes_taken = 0;
        factors_checked = 0;
        cfg_writes = 0;
        idle_pct = 0;

        // Primes below 256 for the ascending stream.
        for (int v = 2; v < 256; v++) begin
            bit is_prime;
            is_prime = 1'b1;
            for (int d = 2; d * d <= v; d++) begin
                if (v % d == 0) is_prime = 1'b0;
            end
            if (is_prime) small_primes.push_back(v);
        end

        // Directed table. After reset n and k are zero, so nothing is reported.
        add_prime(32'd2, 1'b1, 1'b0, 6'd0);
        add_prime(32'hFFFF_FFFF, 1'b1, 1'b0, 6'd0);
        add_prime(32'd0, 1'b1, 1'b0, 6'd0);
        // C(10,3) = 120 = 2^3 * 3 * 5.
        add_cfg(bpe_pkg::REG_N_TOTAL, 32'd10);
        add_cfg(bpe_pkg::REG_K_CHOSEN, 32'd3);
        add_prime(32'd2, 1'b1, 1'b1, 6'd3);
        add_prime(32'd3, 1'b1, 1'b1, 6'd1);
        add_prime(32'd5, 1'b1, 1'b1, 6'd1);
        add_prime(32'd7, 1'b1, 1'b0, 6'd0);
        add_prime(32'd11, 1'b1, 1'b0, 6'd0);
        add_prime(32'd1, 1'b1, 1'b0, 6'd0);
        add_prime(32'd4, 1'b0, 1'b0, 6'd0);
        add_prime(32'd10, 1'b0, 1'b0, 6'd0);
        // k above n gives nothing.
        add_cfg(bpe_pkg::REG_K_CHOSEN, 32'd11);
        add_prime(32'd2, 1'b1, 1'b0, 6'd0);
        add_prime(32'd3, 1'b1, 1'b0, 6'd0);
        // Full-range n.
        add_cfg(bpe_pkg::REG_N_TOTAL, 32'hFFFF_FFFF);
        add_cfg(bpe_pkg::REG_K_CHOSEN, 32'h7FFF_FFFF);
        add_prime(32'd2, 1'b0, 1'b0, 6'd0);
        add_prime(32'd3, 1'b0, 1'b0, 6'd0);
        add_prime(32'hFFFF_FFFB, 1'b0, 1'b0, 6'd0);
        add_prime(32'hFFFF_FFFF, 1'b0, 1'b0, 6'd0);
        // k equal to n or zero: C(n,k) is one.
        add_cfg(bpe_pkg::REG_K_CHOSEN, 32'hFFFF_FFFF);
        add_prime(32'd2, 1'b1, 1'b0, 6'd0);
        add_prime(32'd65521, 1'b1, 1'b0, 6'd0);
        add_cfg(bpe_pkg::REG_K_CHOSEN, 32'd0);
        add_prime(32'd3, 1'b1, 1'b0, 6'd0);
        add_prime(32'd2, 1'b1, 1'b0, 6'd0);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            if (row.is_cfg) begin
                settle(1'b1);
                write_reg(row.reg_idx, row.value);
            end else begin
                send_prime(row.value, row.typed, row.typed_hit, row.typed_exp,
                           $urandom_range(2));
            end
        end

        // Random part: sender idles 9 percent, then 46 percent, then not at all.
        for (int mode = 0; mode < 3; mode++) begin
            idle_pct = (mode == 0) ? 9 : (mode == 1) ? 46 : 0;
            for (int c = 0; c < RAND_CONFIGS; c++) begin
                settle(1'b1);
                random_config();
                idx = $urandom_range(small_primes.size() - 1);
                for (int i = 0; i < ITEMS_PER_CONFIG; i++) begin
                    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(6, 1) : 0;
                    // Once per setting, hold off until every pending factor has arrived.
                    if (i == ITEMS_PER_CONFIG / 2) settle(1'b0);
                    send_prime(next_prime(idx), 1'b0, 1'b0, '0, gap);
                end
            end
        end

        settle(1'b1);
        if (pending_factors.size() != 0) begin
            errors++;
            $display("%0t: %0d expected factors never arrived", $time, pending_factors.size());
        end
        $display("Covered %0d primes over %0d register writes, %0d factors compared.",
                 primes_taken, cfg_writes, factors_checked);
        $display("Settings ranged from n = 0 to n = 2^32 - 1, with k above, equal to and below n.");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/bpe_pkg.sv
rtl/core/bpe_div.sv
rtl/core/bpe_ctrl.sv
rtl/core/binomial_prime_exponent_engine.sv
tb/tb_binomial_prime_exponent_engine.sv
